// ===== rtl/core/qft_pkg.sv =====
package qft_pkg;

    localparam int MAX_DELIMITERS = 4;
    // The delimiter set register holds four bytes, so never more lanes than that.
    localparam int DELIM_LANES = (MAX_DELIMITERS < 4) ? MAX_DELIMITERS : 4;

    localparam int BYTE_W    = 8;
    localparam int INDEX_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 32;
    localparam int COUNT_W   = 3;

    localparam logic [INDEX_W-1:0] INDEX_MAX = '1;

    // Bit positions inside the result tuser.
    localparam int USER_SEP    = 0;
    localparam int USER_QUOTED = 1;
    localparam int USER_W      = 2;

    localparam int M_TDATA_W = BYTE_W + INDEX_W;

    localparam logic [BYTE_W-1:0] QUOTE_OFF = 8'h00;

    localparam logic [CFG_W-1:0]   DELIM_SET_RESET   = 32'd44;
    localparam logic [COUNT_W-1:0] DELIM_COUNT_RESET = 3'd1;
    localparam logic [BYTE_W-1:0]  QUOTE_RESET       = 8'd34;
    localparam logic [BYTE_W-1:0]  ESCAPE_RESET      = 8'd92;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_PLAIN  = 2'd1,
        PH_QUOTED = 2'd2,
        PH_ESCAPE = 2'd3
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DELIM_SET   = 2'd0,
        REG_DELIM_COUNT = 2'd1,
        REG_QUOTE       = 2'd2,
        REG_ESCAPE      = 2'd3
    } cfg_reg_t;

endpackage

// ===== rtl/core/quoted_field_tokenizer.sv =====
// Channel   Direction  Payload
// s_*       in         tdata: data_byte; tlast: end_of_text
// m_*       out        tdata: byte_out, field_index; tlast: field_end;
//                      tuser: is_separator, in_quotes
// cfg_*     in         cfg_index: register number; cfg_data: value
//
// One byte per cycle sustained while the output is not stalled; input and result are both registered.
// The byte is held in an input register, classified against the field state in one
// pass of parallel compares, and registered at the output together with the new state.
// Reset (aresetn low, synchronous) restores the register defaults and field start.
// A stalled output holds both stages; s_tready falls only when both are full.
module quoted_field_tokenizer (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [qft_pkg::BYTE_W-1:0]     s_tdata,   // [7:0] data_byte
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [qft_pkg::M_TDATA_W-1:0]  m_tdata,   // [7:0] byte_out, [23:8] field_index
    output logic                           m_tlast,
    output logic [qft_pkg::USER_W-1:0]     m_tuser,   // [0] is_separator, [1] in_quotes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [qft_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [qft_pkg::CFG_W-1:0]      cfg_data
);
    import qft_pkg::*;

    logic [CFG_W-1:0]   delim_set_reg;
    logic [COUNT_W-1:0] delim_count_reg;
    logic [BYTE_W-1:0]  quote_reg;
    logic [BYTE_W-1:0]  escape_reg;

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic              in_last_reg;

    phase_t             phase_reg, phase_next;
    logic [INDEX_W-1:0] field_counter_reg, field_counter_next;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 out_last_reg;
    logic [USER_W-1:0]    out_user_reg;

    logic advance;
    logic is_delim;
    logic is_quote;
    logic sep;
    logic quoted;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delim_set_reg   <= DELIM_SET_RESET;
            delim_count_reg <= DELIM_COUNT_RESET;
            quote_reg       <= QUOTE_RESET;
            escape_reg      <= ESCAPE_RESET;
        end else if (cfg_valid) begin
            case (cfg_reg_t'(cfg_index))
                REG_DELIM_SET:   delim_set_reg   <= cfg_data;
                REG_DELIM_COUNT: delim_count_reg <= cfg_data[COUNT_W-1:0];
                REG_QUOTE:       quote_reg       <= cfg_data[BYTE_W-1:0];
                REG_ESCAPE:      escape_reg      <= cfg_data[BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    // The result stage moves on when it is empty or its transaction completes.
    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    // Lanes at or above the programmed count are ignored; counts past the lane
    // count simply enable every lane.
    always_comb begin
        is_delim = 1'b0;
        for (int i = 0; i < DELIM_LANES; i++) begin
            if (COUNT_W'(i) < delim_count_reg &&
                delim_set_reg[BYTE_W*i +: BYTE_W] == in_byte_reg) begin
                is_delim = 1'b1;
            end
        end
    end

    assign is_quote = (quote_reg != QUOTE_OFF) && (in_byte_reg == quote_reg);

    always_comb begin
        sep    = 1'b0;
        quoted = 1'b0;
        case (phase_reg)
            PH_START: begin
                quoted = is_quote;
                sep    = !is_quote && is_delim;
            end
            PH_PLAIN: begin
                sep = is_delim;
            end
            PH_QUOTED: begin
                quoted = 1'b1;
            end
            PH_ESCAPE: begin
                quoted = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_START: begin
                if (is_quote) begin
                    phase_next = PH_QUOTED;
                end else if (!is_delim) begin
                    phase_next = PH_PLAIN;
                end
            end
            PH_PLAIN: ;
            PH_QUOTED: begin
                // The escape byte wins when it equals the quote byte.
                if (in_byte_reg == escape_reg) begin
                    phase_next = PH_ESCAPE;
                end else if (in_byte_reg == quote_reg) begin
                    phase_next = PH_PLAIN;
                end
            end
            PH_ESCAPE: begin
                phase_next = PH_QUOTED;
            end
            default: phase_next = PH_START;
        endcase
        if (sep || in_last_reg) begin
            phase_next = PH_START;
        end
    end

    always_comb begin
        field_counter_next = field_counter_reg;
        if (in_last_reg) begin
            field_counter_next = '0;
        end else if (sep && field_counter_reg != INDEX_MAX) begin
            field_counter_next = field_counter_reg + INDEX_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_START;
            field_counter_reg <= '0;
            out_valid_reg     <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg) begin
                phase_reg         <= phase_next;
                field_counter_reg <= field_counter_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_valid_reg) begin
            out_data_reg              <= {field_counter_reg, in_byte_reg};
            out_last_reg              <= sep || in_last_reg;
            out_user_reg[USER_SEP]    <= sep;
            out_user_reg[USER_QUOTED] <= quoted;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_user_reg;

    // A separator is never part of a quoted region and always closes a field.
    a_sep_unquoted: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[USER_SEP] |-> !m_tuser[USER_QUOTED] && m_tlast)
        else $error("separator marked as quoted or not closing a field");

    // The last byte of a text leaves the tokenizer at field start for the next text.
    a_text_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg && in_last_reg |=>
            field_counter_reg == '0 && phase_reg == PH_START)
        else $error("state not restored after end of text");

    // Within a text the field number never goes backwards.
    a_index_monotonic: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg && !in_last_reg |=>
            field_counter_reg >= $past(field_counter_reg))
        else $error("field number decreased within a text");

    // Every byte taken from the input register is presented at the output.
    a_result_follows: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && in_valid_reg |=> m_tvalid)
        else $error("processed byte produced no result");

endmodule

// ===== tb/sv/quoted_field_tokenizer_tb.sv =====
`timescale 1ns / 1ps

module quoted_field_tokenizer_tb;
    import qft_pkg::*;

    localparam int STALL_LIMIT = 20000;
    localparam int SEGMENTS    = 10;
    localparam int SEG_ITEMS   = 200;

    typedef struct packed {
        logic [BYTE_W-1:0]  data_val;
        logic               sep;
        logic               fend;
        logic               quoted;
        logic [INDEX_W-1:0] field_idx;
    } token_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [BYTE_W-1:0]     s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic [USER_W-1:0]     m_tuser;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;

    // Shadow copy of the block's registers and field state.
    logic [CFG_W-1:0]      delim_set_reg;
    logic [COUNT_W-1:0]    delim_count_reg;
    logic [BYTE_W-1:0]     quote_reg;
    logic [BYTE_W-1:0]     escape_reg;
    phase_t                cur_phase;
    logic [INDEX_W-1:0]    field_count;

    token_t                expected_tokens[$];
    int                    error_count = 0;
    int                    idle_cycles = 0;
    int                    src_idle_pct = 0;
    int                    sink_idle_pct = 0;

    quoted_field_tokenizer dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
    end

    function automatic int active_lanes();
        int n;
        n = delim_count_reg;
        if (n > 4) n = 4;
        if (n > DELIM_LANES) n = DELIM_LANES;
        return n;
    endfunction

    function automatic logic is_delimiter(input logic [BYTE_W-1:0] data);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < active_lanes(); i++) begin
            if (delim_set_reg[8*i +: 8] == data) hit = 1'b1;
        end
        return hit;
    endfunction

    // Classifies one byte against the current field state and advances that state.
    function automatic token_t tokenize_byte(input logic [BYTE_W-1:0] data, input logic eot);
        token_t t;
        t.data_val  = data;
        t.sep       = 1'b0;
        t.quoted    = 1'b0;
        t.field_idx = field_count;
        case (cur_phase)
            PH_START: begin
                if (quote_reg != QUOTE_OFF && data == quote_reg) begin
                    t.quoted  = 1'b1;
                    cur_phase = PH_QUOTED;
                end else if (is_delimiter(data)) begin
                    t.sep = 1'b1;
                end else begin
                    cur_phase = PH_PLAIN;
                end
            end
            PH_PLAIN: begin
                if (is_delimiter(data)) t.sep = 1'b1;
            end
            PH_QUOTED: begin
                t.quoted = 1'b1;
                if (data == escape_reg) cur_phase = PH_ESCAPE;
                else if (data == quote_reg) cur_phase = PH_PLAIN;
            end
            default: begin
                t.quoted  = 1'b1;
                cur_phase = PH_QUOTED;
            end
        endcase
        if (t.sep) begin
            cur_phase = PH_START;
            if (field_count != INDEX_MAX) field_count = field_count + INDEX_W'(1);
        end
        t.fend = t.sep || eot;
        if (eot) begin
            cur_phase   = PH_START;
            field_count = '0;
        end
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("%0t: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        error_count++;
    endtask

    always @(posedge aclk) begin : check_results
        token_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_tokens.size() == 0) begin
                report_mismatch("unexpected result", m_tdata, 0);
            end else begin
                want = expected_tokens.pop_front();
                if (m_tdata[BYTE_W-1:0] !== want.data_val)
                    report_mismatch("byte_out", m_tdata[BYTE_W-1:0], want.data_val);
                if (m_tdata[BYTE_W +: INDEX_W] !== want.field_idx)
                    report_mismatch("field_index", m_tdata[BYTE_W +: INDEX_W], want.field_idx);
                if (m_tlast !== want.fend)
                    report_mismatch("field_end", m_tlast, want.fend);
                if (m_tuser[USER_SEP] !== want.sep)
                    report_mismatch("is_separator", m_tuser[USER_SEP], want.sep);
                if (m_tuser[USER_QUOTED] !== want.quoted)
                    report_mismatch("in_quotes", m_tuser[USER_QUOTED], want.quoted);
            end
        end
    end

    // Ends the run when no transaction of any kind has happened for too long.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic set_idling(input int src_pct, input int sink_pct);
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
    endtask

    // Leaves s_tvalid high after the transaction so that back-to-back bytes need no gap.
    task automatic send_byte(input logic [BYTE_W-1:0] data, input logic eot);
        if ($urandom_range(0, 99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= eot;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_tokens.push_back(tokenize_byte(data, eot));
    endtask

    task automatic send_text(input string text, input logic eot_at_end);
        for (int i = 0; i < text.len(); i++)
            send_byte(text[i], eot_at_end && (i == text.len() - 1));
    endtask

    // Holds the input until every result is out, then lets the pipeline settle.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_tokens.size() != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic put_reg(input cfg_reg_t which, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= which;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (which)
            REG_DELIM_SET:   delim_set_reg   = value;
            REG_DELIM_COUNT: delim_count_reg = value[COUNT_W-1:0];
            REG_QUOTE:       quote_reg       = value[BYTE_W-1:0];
            REG_ESCAPE:      escape_reg      = value[BYTE_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [CFG_W-1:0] dset, input logic [COUNT_W-1:0] dcount,
                              input logic [BYTE_W-1:0] quote, input logic [BYTE_W-1:0] esc);
        wait_idle();
        put_reg(REG_DELIM_SET, dset);
        put_reg(REG_DELIM_COUNT, dcount);
        put_reg(REG_QUOTE, quote);
        put_reg(REG_ESCAPE, esc);
        cfg_valid <= 1'b0;
    endtask

    // Default registers: empty fields, quoted delimiter, escaped quote, content after
    // the closing quote, zero and all-ones bytes, trailing delimiter and open quote at end.
    task automatic test_default_fields();
        set_idling(28, 84);
        send_text("a,,\"b,\\\"c\"d,", 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_text("x,", 1'b1);
        send_text("\"a,", 1'b1);
    endtask

    task automatic test_delimiter_options();
        set_idling(28, 84);
        set_config(32'h3B3A_092C, 3'd4, 8'h22, 8'h5C);
        send_text("a\tb:c;d", 1'b1);
        // A count above four still uses only the four lanes.
        set_config(32'h7C3B_3A2C, 3'd7, 8'h22, 8'h5C);
        send_text("x|y", 1'b1);
        set_config(32'h7C3B_3A2C, 3'd0, 8'h22, 8'h5C);
        send_text("a,b", 1'b1);
        // The quote doubles as a delimiter: it opens a quoted region at field start only.
        set_config(32'h0000_002C, 3'd1, 8'h2C, 8'h5C);
        send_text(",a,b,c", 1'b1);
        // With escape equal to quote, a doubled quote stays inside the quotes.
        set_config(32'h0000_002C, 3'd1, 8'h22, 8'h22);
        send_text("\"a\"\",b", 1'b1);
        // Quoting off and zero as a delimiter.
        set_config(32'h0000_0000, 3'd1, QUOTE_OFF, 8'h00);
        send_byte(8'h61, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h22, 1'b1);
    endtask

    function automatic logic [BYTE_W-1:0] pick_text_byte();
        int r;
        int lanes;
        r     = $urandom_range(0, 99);
        lanes = active_lanes();
        if (r < 30 && lanes > 0) return delim_set_reg[8*$urandom_range(0, lanes - 1) +: 8];
        if (r < 42) return quote_reg;
        if (r < 52) return escape_reg;
        return BYTE_W'($urandom_range(0, 255));
    endfunction

    task automatic test_random_text();
        logic [CFG_W-1:0]   dset;
        logic [COUNT_W-1:0] dcount;
        logic [BYTE_W-1:0]  quote;
        logic [BYTE_W-1:0]  esc;
        logic [BYTE_W-1:0]  data;
        for (int seg = 0; seg < SEGMENTS; seg++) begin
            if (seg < 4) set_idling(28, 84);
            else if (seg < 7) set_idling(84, 28);
            else set_idling(0, 0);
            if (seg == 0) begin
                set_config('1, '1, 8'hFF, 8'hFF);
            end else if (seg == 1) begin
                set_config('0, '0, QUOTE_OFF, 8'h00);
            end else begin
                dset   = ($urandom_range(0, 9) == 0) ? '0 : CFG_W'($urandom());
                dcount = COUNT_W'($urandom_range(0, 7));
                case ($urandom_range(0, 4))
                    0:       quote = QUOTE_OFF;
                    1:       quote = 8'hFF;
                    2:       quote = dset[7:0];
                    default: quote = BYTE_W'($urandom_range(0, 255));
                endcase
                case ($urandom_range(0, 4))
                    0:       esc = 8'h00;
                    1:       esc = 8'hFF;
                    2:       esc = quote;
                    default: esc = BYTE_W'($urandom_range(0, 255));
                endcase
                set_config(dset, dcount, quote, esc);
            end
            for (int i = 0; i < SEG_ITEMS; i++) begin
                if (i == SEG_ITEMS / 2) wait_idle();
                if ($urandom_range(0, 9) == 0) data = BYTE_W'($urandom_range(0, 255));
                else data = pick_text_byte();
                send_byte(data, $urandom_range(0, 15) == 0);
            end
        end
    endtask

    initial begin
        aresetn   <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tlast   <= 1'b0;
        m_tready  <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_DELIM_SET;
        cfg_data  <= '0;
        delim_set_reg   = DELIM_SET_RESET;
        delim_count_reg = DELIM_COUNT_RESET;
        quote_reg       = QUOTE_RESET;
        escape_reg      = ESCAPE_RESET;
        cur_phase       = PH_START;
        field_count     = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_default_fields();
        test_delimiter_options();
        test_random_text();
        wait_idle();

        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
